[rtl/cfds_pkg.sv]
// Shared types, widths and keyword tables for the function definition scanner.
// Used by cfds_lexer, cfds_parser and c_function_definition_scanner_top.
`timescale 1ns / 1ps

package cfds_pkg;

   // Position counter and token length widths
   localparam int OFFSET_BITS = 24;
   localparam int LENGTH_BITS = 16;

   // Number of keywords matched by prefix
   localparam logic [2:0] KW_COUNT = 3'd7;

   // Character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // Lexer mode, one-hot
   typedef enum logic [2:0] {
      LEX_BETWEEN = 3'b001,
      LEX_KEYWORD = 3'b010,
      LEX_WORD    = 3'b100
   } lex_mode_type;

   // Token kinds seen by the parser
   typedef enum logic [2:0] {
      TK_WORD,
      TK_LPAR,
      TK_RPAR,
      TK_LBRACE,
      TK_RBRACE,
      TK_OTHER,
      TK_END
   } tok_kind_type;

   // Parser state, one-hot
   typedef enum logic [5:0] {
      ST_TYPE   = 6'b000001,
      ST_NAME   = 6'b000010,
      ST_OPEN   = 6'b000100,
      ST_PARAMS = 6'b001000,
      ST_BRACE  = 6'b010000,
      ST_BODY   = 6'b100000
   } scan_state_type;

   // Tokens produced by one byte, in the order the parser takes them:
   // a word closed by this byte, the token this byte makes, a word left
   // open at the last byte, and the end of text from the last byte.
   typedef struct packed {
      logic                   a_valid;
      logic [OFFSET_BITS-1:0] a_start;
      logic [LENGTH_BITS-1:0] a_length;
      logic                   b_valid;
      tok_kind_type           b_kind;
      logic                   c_valid;
      logic [OFFSET_BITS-1:0] c_start;
      logic [LENGTH_BITS-1:0] c_length;
      logic                   d_end;
   } tokens_type;

   // Letter class tests
   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_word_char(input logic [7:0] b);
      return is_letter(b) || (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDER);
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   // Leading letter of each keyword: {hit, index}
   function automatic logic [3:0] kw_lead_match(input logic [7:0] b);
      logic [3:0] r;
      unique case (b)
         8'h69:   r = {1'b1, 3'd0}; // i
         8'h65:   r = {1'b1, 3'd1}; // e
         8'h77:   r = {1'b1, 3'd2}; // w
         8'h66:   r = {1'b1, 3'd3}; // f
         8'h72:   r = {1'b1, 3'd4}; // r
         8'h62:   r = {1'b1, 3'd5}; // b
         8'h63:   r = {1'b1, 3'd6}; // c
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // Tail length of each keyword
   function automatic logic [2:0] kw_tail_len(input logic [2:0] k);
      logic [2:0] r;
      unique case (k)
         3'd0:    r = 3'd1;
         3'd1:    r = 3'd3;
         3'd2:    r = 3'd4;
         3'd3:    r = 3'd2;
         3'd4:    r = 3'd5;
         3'd5:    r = 3'd4;
         3'd6:    r = 3'd3;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Tail characters: "f", "lse", "hile", "or", "eturn", "reak", "ase"
   function automatic logic [7:0] kw_tail_char(input logic [2:0] k, input logic [2:0] p);
      logic [7:0] r;
      r = CH_NUL;
      unique case (k)
         3'd0: r = 8'h66;
         3'd1: begin
            unique case (p)
               3'd0:    r = 8'h6C;
               3'd1:    r = 8'h73;
               default: r = 8'h65;
            endcase
         end
         3'd2: begin
            unique case (p)
               3'd0:    r = 8'h68;
               3'd1:    r = 8'h69;
               3'd2:    r = 8'h6C;
               default: r = 8'h65;
            endcase
         end
         3'd3: r = (p == 3'd0) ? 8'h6F : 8'h72;
         3'd4: begin
            unique case (p)
               3'd0:    r = 8'h65;
               3'd1:    r = 8'h74;
               3'd2:    r = 8'h75;
               3'd3:    r = 8'h72;
               default: r = 8'h6E;
            endcase
         end
         3'd5: begin
            unique case (p)
               3'd0:    r = 8'h72;
               3'd1:    r = 8'h65;
               3'd2:    r = 8'h61;
               default: r = 8'h6B;
            endcase
         end
         3'd6: begin
            unique case (p)
               3'd0:    r = 8'h61;
               3'd1:    r = 8'h73;
               default: r = 8'h65;
            endcase
         end
         default: r = CH_NUL;
      endcase
      return r;
   endfunction

endpackage

[rtl/c_function_definition_scanner_top.sv]
// Top level of the function definition scanner: input and result registers.
// Depends on cfds_pkg, cfds_lexer and cfds_parser.
`timescale 1ns / 1ps

// Streams source text one byte per word and reports each function definition
// of the form "ident ident ( ... ) { ... }" (no nesting) by the start offset
// and length of the function name. A zero byte, or a word with last_byte set,
// ends the scan with a word carrying scan_done; later words are taken and
// dropped until reset. A byte enters the input register, and when the result
// register is free the lexer and token machine consume it and load the result
// register, so one byte is taken every cycle while rsp_stall is low; the
// per-byte state update (lexer plus token machine) sets that rate.
// Bytes that produce no result leave no word on the result channel.
module c_function_definition_scanner_top
   import cfds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_src_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_name_offset,
   output logic [15:0] rsp_name_length,
   output logic        rsp_name_valid,
   output logic        rsp_scan_done
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [OFFSET_BITS-1:0] out_offset_ff;
   logic [LENGTH_BITS-1:0] out_length_ff;
   logic                   out_name_ff;
   logic                   out_done_ff;

   logic                   can_take;
   logic                   fire;
   logic                   req_take;
   tokens_type             tokens;
   logic                   halted;
   logic                   report;
   logic                   done;
   logic [OFFSET_BITS-1:0] name_start;
   logic [LENGTH_BITS-1:0] name_length;

   // Handshake: the byte stage moves when the result register is free
   assign can_take  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && can_take;
   assign req_stall = in_valid_ff && !can_take;
   assign req_take  = req_valid && !req_stall;

   cfds_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step      (fire),
      .halted    (halted),
      .src_byte  (in_byte_ff),
      .last_byte (in_last_ff),
      .tokens    (tokens)
   );

   cfds_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (fire),
      .tokens      (tokens),
      .halted      (halted),
      .report      (report),
      .done        (done),
      .name_start  (name_start),
      .name_length (name_length)
   );

   // Input register valid
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = report || done;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_src_byte;
         in_last_ff <= req_last_byte;
      end
      if (fire) begin
         out_offset_ff <= report ? name_start : '0;
         out_length_ff <= report ? name_length : '0;
         out_name_ff   <= report;
         out_done_ff   <= done;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_name_offset = out_offset_ff;
   assign rsp_name_length = out_length_ff;
   assign rsp_name_valid  = out_name_ff;
   assign rsp_scan_done   = out_done_ff;

endmodule

[rtl/cfds_lexer.sv]
// Byte lexer: position counter, lexer mode, keyword tracking, open token.
// Depends on cfds_pkg.
`timescale 1ns / 1ps

module cfds_lexer
   import cfds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       halted,
   input  logic [7:0] src_byte,
   input  logic       last_byte,
   output tokens_type tokens
);

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   lex_mode_type           mode_ff, mode_in;
   logic [2:0]             choice_ff, choice_in;
   logic [2:0]             prog_ff, prog_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   logic                   go;
   logic                   in_word;
   logic                   run_begin;
   logic [2:0]             prog_inc;
   logic [2:0]             tail_len;
   logic [3:0]             lead;
   logic [LENGTH_BITS-1:0] len_grown;

   assign go        = step && !halted;
   assign prog_inc  = prog_ff + 3'd1;
   assign tail_len  = kw_tail_len(choice_ff);
   assign lead      = kw_lead_match(src_byte);
   assign len_grown = (len_ff != '1) ? len_ff + LENGTH_BITS'(1) : len_ff;

   // Next lexer state and tokens for this byte
   always_comb begin
      pos_in    = pos_ff;
      mode_in   = mode_ff;
      choice_in = choice_ff;
      prog_in   = prog_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      in_word   = 1'b0;
      run_begin = 1'b0;
      tokens    = '0;
      tokens.b_kind   = TK_OTHER;
      tokens.a_start  = start_ff;
      tokens.a_length = len_ff;

      if (go) begin
         pos_in = pos_ff + OFFSET_BITS'(1);

         // keyword tail match, else fall into word mode
         if (mode_ff == LEX_KEYWORD) begin
            if (choice_ff < KW_COUNT && prog_ff < tail_len &&
                kw_tail_char(choice_ff, prog_ff) == src_byte) begin
               prog_in = prog_inc;
               len_in  = len_grown;
               if (prog_inc >= tail_len) begin
                  tokens.b_valid = 1'b1;
                  tokens.b_kind  = TK_OTHER;
                  mode_in        = LEX_BETWEEN;
               end
            end else begin
               in_word = 1'b1;
            end
         end else if (mode_ff == LEX_WORD) begin
            in_word = 1'b1;
         end else begin
            run_begin = 1'b1;
         end

         // identifier growth or close
         if (in_word) begin
            if (is_word_char(src_byte)) begin
               len_in  = len_grown;
               mode_in = LEX_WORD;
            end else begin
               tokens.a_valid = 1'b1;
               run_begin      = 1'b1;
            end
         end

         // start of a new token
         if (run_begin) begin
            mode_in = LEX_BETWEEN;
            if (is_blank(src_byte)) begin
               tokens.b_valid = 1'b0;
            end else if (src_byte == CH_NUL) begin
               tokens.b_valid = 1'b1;
               tokens.b_kind  = TK_END;
            end else if (src_byte == CH_LPAR) begin
               tokens.b_valid = 1'b1;
               tokens.b_kind  = TK_LPAR;
            end else if (src_byte == CH_RPAR) begin
               tokens.b_valid = 1'b1;
               tokens.b_kind  = TK_RPAR;
            end else if (src_byte == CH_LBRACE) begin
               tokens.b_valid = 1'b1;
               tokens.b_kind  = TK_LBRACE;
            end else if (src_byte == CH_RBRACE) begin
               tokens.b_valid = 1'b1;
               tokens.b_kind  = TK_RBRACE;
            end else if (!is_letter(src_byte)) begin
               tokens.b_valid = 1'b1;
               tokens.b_kind  = TK_OTHER;
            end else begin
               start_in = pos_ff;
               len_in   = LENGTH_BITS'(1);
               mode_in  = LEX_WORD;
               if (lead[3]) begin
                  mode_in   = LEX_KEYWORD;
                  choice_in = lead[2:0];
                  prog_in   = 3'd0;
               end
            end
         end

         // last byte: close an open token, then end of text
         if (last_byte && !(tokens.b_valid && tokens.b_kind == TK_END)) begin
            if (mode_in == LEX_KEYWORD || mode_in == LEX_WORD) begin
               tokens.c_valid  = 1'b1;
               tokens.c_start  = start_in;
               tokens.c_length = len_in;
            end
            mode_in      = LEX_BETWEEN;
            tokens.d_end = 1'b1;
         end
      end
   end

   // Lexer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         mode_ff   <= LEX_BETWEEN;
         choice_ff <= 3'd0;
         prog_ff   <= 3'd0;
         start_ff  <= '0;
         len_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         mode_ff   <= mode_in;
         choice_ff <= choice_in;
         prog_ff   <= prog_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
      end
   end

endmodule

[rtl/cfds_parser.sv]
// Token machine: finds ident ident ( ... ) { ... } and holds the name.
// Depends on cfds_pkg; takes up to four tokens per byte from cfds_lexer.
`timescale 1ns / 1ps

module cfds_parser
   import cfds_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  tokens_type             tokens,
   output logic                   halted,
   output logic                   report,
   output logic                   done,
   output logic [OFFSET_BITS-1:0] name_start,
   output logic [LENGTH_BITS-1:0] name_length
);

   typedef struct packed {
      scan_state_type         state;
      logic [OFFSET_BITS-1:0] held_start;
      logic [LENGTH_BITS-1:0] held_length;
      logic                   halted;
      logic                   report;
      logic                   done;
   } scan_type;

   scan_state_type         state_ff;
   logic [OFFSET_BITS-1:0] held_start_ff;
   logic [LENGTH_BITS-1:0] held_length_ff;
   logic                   halted_ff;

   scan_type s0, s1, s2, s3, s4;

   // One token through the machine
   function automatic scan_type scan_apply(
      input scan_type               s,
      input logic                   v,
      input tok_kind_type           kind,
      input logic [OFFSET_BITS-1:0] start,
      input logic [LENGTH_BITS-1:0] length
   );
      scan_type r;
      r = s;
      if (v && !s.halted) begin
         if (kind == TK_END) begin
            r.halted = 1'b1;
            r.done   = 1'b1;
         end else begin
            unique case (s.state)
               ST_TYPE: r.state = (kind == TK_WORD) ? ST_NAME : ST_TYPE;
               ST_NAME: begin
                  if (kind == TK_WORD) begin
                     r.held_start  = start;
                     r.held_length = length;
                     r.state       = ST_OPEN;
                  end else begin
                     r.state = ST_TYPE;
                  end
               end
               ST_OPEN:   r.state = (kind == TK_LPAR) ? ST_PARAMS : ST_TYPE;
               ST_PARAMS: r.state = (kind == TK_RPAR) ? ST_BRACE : ST_PARAMS;
               ST_BRACE:  r.state = (kind == TK_LBRACE) ? ST_BODY : ST_TYPE;
               ST_BODY: begin
                  if (kind == TK_RBRACE) begin
                     r.report = 1'b1;
                     r.state  = ST_TYPE;
                  end
               end
               default: r.state = ST_TYPE;
            endcase
         end
      end
      return r;
   endfunction

   // Token chain for one byte
   always_comb begin
      s0 = '{state: state_ff, held_start: held_start_ff, held_length: held_length_ff,
             halted: halted_ff, report: 1'b0, done: 1'b0};
      s1 = scan_apply(s0, tokens.a_valid, TK_WORD, tokens.a_start, tokens.a_length);
      s2 = scan_apply(s1, tokens.b_valid, tokens.b_kind, '0, '0);
      s3 = scan_apply(s2, tokens.c_valid, TK_WORD, tokens.c_start, tokens.c_length);
      s4 = scan_apply(s3, tokens.d_end, TK_END, '0, '0);
   end

   assign halted      = halted_ff;
   assign report      = step && s4.report;
   assign done        = step && s4.done;
   assign name_start  = s4.held_start;
   assign name_length = s4.held_length;

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_TYPE;
         held_start_ff  <= '0;
         held_length_ff <= '0;
         halted_ff      <= 1'b0;
      end else if (step) begin
         state_ff       <= s4.state;
         held_start_ff  <= s4.held_start;
         held_length_ff <= s4.held_length;
         halted_ff      <= s4.halted;
      end
   end

endmodule

[test/c_function_definition_scanner_top_tb.sv]
// Testbench for c_function_definition_scanner_top: streams C-like source text and
// checks every result word against a behavioral predictor of the lexer and token machine.
// Depends on cfds_pkg and the scanner RTL.
`timescale 1ns / 1ps

module c_function_definition_scanner_top_tb
   import cfds_pkg::*;
();

   // Traffic phases: idle and stall percentages for sender and receiver
   localparam logic [1:0] PH_STEADY      = 2'd0;
   localparam logic [1:0] PH_SEND_GAPS   = 2'd1;
   localparam logic [1:0] PH_RECV_STALLS = 2'd2;
   localparam logic [1:0] PH_BOTH        = 2'd3;
   localparam int unsigned RANDOM_PER_PHASE = 325;
   localparam int unsigned CYCLE_LIMIT      = 600000;
   localparam int unsigned DRAIN_CYCLES     = 12;

   int unsigned send_gap_pct [4]   = '{0, 76, 0, 16};
   int unsigned recv_stall_pct [4] = '{0, 0, 76, 16};

   // Keywords matched by prefix, lead letter first
   string kw_words [7] = '{"if", "else", "while", "for", "return", "break", "case"};
   string punct = ";,+-*&=<>!.?#[]";

   typedef struct packed {
      logic [7:0] src;
      logic       last;
      logic [1:0] phase;
   } src_word_type;

   typedef struct packed {
      logic [23:0] offset;
      logic [15:0] length;
      logic        name_valid;
      logic        done;
   } finding_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_src_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [23:0] rsp_name_offset;
   logic [15:0] rsp_name_length;
   logic        rsp_name_valid;
   logic        rsp_scan_done;

   src_word_type pending [$];
   finding_type  expected_findings [$];
   src_word_type next_word;
   finding_type  want;
   logic [1:0]  fill_phase = PH_STEADY;
   logic [1:0]  phase = PH_STEADY;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned phase_base;

   // Predictor state
   lex_mode_type   lx_mode = LEX_BETWEEN;
   int unsigned    kw_sel = 0;
   int unsigned    kw_pos = 0;
   logic [23:0]    cur_pos = '0;
   logic [23:0]    word_start = '0;
   logic [15:0]    word_len = '0;
   scan_state_type parse_st = ST_TYPE;
   logic [23:0]    name_start = '0;
   logic [15:0]    name_len = '0;
   logic           stopped = 1'b0;
   logic           saw_def;
   logic           saw_end;

   c_function_definition_scanner_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_src_byte    (req_src_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_name_offset (rsp_name_offset),
      .rsp_name_length (rsp_name_length),
      .rsp_name_valid  (rsp_name_valid),
      .rsp_scan_done   (rsp_scan_done)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic logic alpha_char(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic ident_char(input logic [7:0] b);
      return alpha_char(b) || (b >= "0" && b <= "9") || b == CH_UNDER;
   endfunction

   function automatic logic blank_char(input logic [7:0] b);
      return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
   endfunction

   // Token machine: ident ident ( ... ) { ... }
   task parse_token(input tok_kind_type kind);
      if (!stopped) begin
         if (kind == TK_END) begin
            stopped = 1'b1;
            saw_end = 1'b1;
         end else begin
            case (parse_st)
               ST_TYPE: if (kind == TK_WORD) parse_st = ST_NAME;
               ST_NAME: begin
                  if (kind == TK_WORD) begin
                     name_start = word_start;
                     name_len   = word_len;
                     parse_st   = ST_OPEN;
                  end else begin
                     parse_st = ST_TYPE;
                  end
               end
               ST_OPEN:   parse_st = (kind == TK_LPAR) ? ST_PARAMS : ST_TYPE;
               ST_PARAMS: if (kind == TK_RPAR) parse_st = ST_BRACE;
               ST_BRACE:  parse_st = (kind == TK_LBRACE) ? ST_BODY : ST_TYPE;
               ST_BODY: begin
                  if (kind == TK_RBRACE) begin
                     saw_def  = 1'b1;
                     parse_st = ST_TYPE;
                  end
               end
               default: parse_st = ST_TYPE;
            endcase
         end
      end
   endtask

   task grow_word();
      if (word_len != 16'hFFFF) word_len = word_len + 16'd1;
   endtask

   // A byte seen between tokens
   task start_token(input logic [7:0] b);
      lx_mode = LEX_BETWEEN;
      if (!blank_char(b)) begin
         case (b)
            CH_NUL:    parse_token(TK_END);
            CH_LPAR:   parse_token(TK_LPAR);
            CH_RPAR:   parse_token(TK_RPAR);
            CH_LBRACE: parse_token(TK_LBRACE);
            CH_RBRACE: parse_token(TK_RBRACE);
            default: begin
               if (!alpha_char(b)) begin
                  parse_token(TK_OTHER);
               end else begin
                  word_start = cur_pos;
                  word_len   = 16'd1;
                  lx_mode    = LEX_WORD;
                  for (int k = 0; k < 7; k++) begin
                     if (lx_mode == LEX_WORD && kw_words[k][0] == b) begin
                        lx_mode = LEX_KEYWORD;
                        kw_sel  = k;
                        kw_pos  = 0;
                     end
                  end
               end
            end
         endcase
      end
   endtask

   task lex_char(input logic [7:0] b);
      logic handled;
      handled = 1'b0;
      if (lx_mode == LEX_KEYWORD) begin
         if (kw_pos < kw_words[kw_sel].len() - 1 && kw_words[kw_sel][kw_pos + 1] == b) begin
            kw_pos = kw_pos + 1;
            grow_word();
            // complete keyword is a non-word token, whatever follows
            if (kw_pos >= kw_words[kw_sel].len() - 1) begin
               parse_token(TK_OTHER);
               lx_mode = LEX_BETWEEN;
            end
            handled = 1'b1;
         end else begin
            lx_mode = LEX_WORD;
         end
      end
      if (!handled && lx_mode == LEX_WORD) begin
         if (ident_char(b)) begin
            grow_word();
            handled = 1'b1;
         end else begin
            // closing byte is lexed again as a fresh token below
            parse_token(TK_WORD);
            lx_mode = LEX_BETWEEN;
         end
      end
      if (!handled) start_token(b);
   endtask

   // Work out the result word (if any) caused by one accepted byte
   task predict_findings(input logic [7:0] b, input logic last);
      if (!stopped) begin
         saw_def = 1'b0;
         saw_end = 1'b0;
         lex_char(b);
         cur_pos = cur_pos + 24'd1;
         if (last && !stopped) begin
            // open token at the end counts as an identifier
            if (lx_mode != LEX_BETWEEN) parse_token(TK_WORD);
            lx_mode = LEX_BETWEEN;
            parse_token(TK_END);
         end
         if (saw_def || saw_end) begin
            expected_findings.push_back('{saw_def ? name_start : 24'd0,
                                          saw_def ? name_len : 16'd0,
                                          saw_def, saw_end});
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------
   task put_byte(input logic [7:0] b, input logic last = 1'b0);
      pending.push_back('{b, last, fill_phase});
   endtask

   task put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task put_blank();
      if ($urandom_range(3) == 0) put_byte(8'($urandom_range(9, 13)));
      else put_byte(CH_SPACE);
   endtask

   function automatic logic [7:0] rand_letter();
      int unsigned idx;
      idx = $urandom_range(51);
      return (idx < 26) ? 8'("a" + idx) : 8'("A" + idx - 26);
   endfunction

   // Identifier, keyword, or keyword-prefixed word
   task put_word();
      int unsigned tail;
      tail = $urandom_range(7);
      if ($urandom_range(6) == 0) begin
         put_text(kw_words[$urandom_range(6)]);
         tail = $urandom_range(2);
      end else if ($urandom_range(3) == 0) begin
         put_byte(kw_words[$urandom_range(6)][0]);
      end else begin
         put_byte(rand_letter());
      end
      repeat (tail) begin
         case ($urandom_range(3))
            0:       put_byte(8'("0" + $urandom_range(9)));
            1:       put_byte(CH_UNDER);
            default: put_byte(rand_letter());
         endcase
      end
   endtask

   // Token inside a parameter list or body; never closes it
   task put_filler(input logic in_body);
      string nest;
      nest = in_body ? "({)" : "({}";
      case ($urandom_range(5))
         0, 1: begin
            put_word();
            put_blank();
         end
         2:       put_byte(punct[$urandom_range(punct.len() - 1)]);
         3:       put_byte(8'($urandom_range(128, 255)));
         4:       put_byte(nest[$urandom_range(2)]);
         default: put_blank();
      endcase
   endtask

   // Mostly well-formed definitions, now and then a broken one
   task put_definition();
      int unsigned flaw;
      flaw = $urandom_range(9);
      if (flaw != 0) begin
         put_word();
         put_blank();
         if ($urandom_range(1)) put_blank();
      end
      put_word();
      if ($urandom_range(1)) put_blank();
      if (flaw == 1) put_byte(";");
      put_byte(CH_LPAR);
      repeat ($urandom_range(4)) put_filler(1'b0);
      put_byte(CH_RPAR);
      if ($urandom_range(1)) put_blank();
      if (flaw == 2) begin
         put_word();
         put_blank();
      end
      put_byte(CH_LBRACE);
      repeat ($urandom_range(5)) put_filler(1'b1);
      put_byte(CH_RBRACE);
      if ($urandom_range(1)) put_blank();
   endtask

   task put_noise();
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(1, 255)));
   endtask

   task put_random_phase(input logic [1:0] ph);
      fill_phase = ph;
      phase_base = pending.size();
      while (pending.size() - phase_base < RANDOM_PER_PHASE) begin
         if ($urandom_range(9) < 8) put_definition();
         else put_noise();
      end
   endtask

   // ---------------------------------------------------------------
   // Driver: presents queued words, holds them while stalled
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_findings(req_src_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (pending.size() != 0 &&
                $urandom_range(99) >= send_gap_pct[pending[0].phase]) begin
               next_word = pending.pop_front();
               req_valid     <= 1'b1;
               req_src_byte  <= next_word.src;
               req_last_byte <= next_word.last;
               phase         <= next_word.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks result words in order, drives random stall
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_findings.size() == 0) begin
               $error("result word with no expectation: offset %0d length %0d valid %0d done %0d",
                      rsp_name_offset, rsp_name_length, rsp_name_valid, rsp_scan_done);
               mismatches++;
            end else begin
               want = expected_findings.pop_front();
               if (rsp_name_offset !== want.offset) begin
                  $error("name_offset: expected %0d, got %0d", want.offset, rsp_name_offset);
                  mismatches++;
               end
               if (rsp_name_length !== want.length) begin
                  $error("name_length: expected %0d, got %0d", want.length, rsp_name_length);
                  mismatches++;
               end
               if (rsp_name_valid !== want.name_valid) begin
                  $error("name_valid: expected %0d, got %0d", want.name_valid, rsp_name_valid);
                  mismatches++;
               end
               if (rsp_scan_done !== want.done) begin
                  $error("scan_done: expected %0d, got %0d", want.done, rsp_scan_done);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct[phase]);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("c_function_definition_scanner_top_tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      // directed: simple definition, upper case, digits, underscore, tab,
      // vertical tab, high byte in the parameters, closing byte right after a name
      fill_phase = PH_STEADY;
      put_text("int main(){}");
      put_text("Z_9\tb");
      put_byte(8'h0B);
      put_byte(CH_LPAR);
      put_byte(8'hFF);
      put_text("){}");

      put_random_phase(PH_STEADY);
      put_random_phase(PH_SEND_GAPS);
      put_random_phase(PH_RECV_STALLS);
      put_random_phase(PH_BOTH);

      // end of text: zero byte, closing brace on the last byte, or open keyword
      case ($urandom_range(2))
         0: put_byte(CH_NUL, 1'($urandom_range(1)));
         1: begin
            put_text("int f1(){");
            put_byte(CH_RBRACE, 1'b1);
         end
         default: begin
            put_text(" ret");
            put_byte("u", 1'b1);
         end
      endcase
      // taken and dropped after the scan has ended
      put_byte(8'hFF, 1'b1);
      put_byte(CH_NUL);
      put_text("a b(){}");

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending.size() != 0 || req_valid) @(posedge clock);
      while (expected_findings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("c_function_definition_scanner_top_tb OK");
      end else begin
         $display("c_function_definition_scanner_top_tb NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
rtl/cfds_pkg.sv
rtl/cfds_lexer.sv
rtl/cfds_parser.sv
rtl/c_function_definition_scanner_top.sv
test/c_function_definition_scanner_top_tb.sv
